// File: rtl/core/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Expects signals clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define NSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define NSD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/nsd_pkg.sv
// Types and constants of the netstring deframer.
// No dependencies; used by every module of the block.
package nsd_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] MAX_LENGTH_RESET = 32'd65535;

    localparam logic [1:0] PH_LEN   = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_COMMA = 2'd2;

    localparam logic [1:0] K_HDR  = 2'd0;
    localparam logic [1:0] K_DATA = 2'd1;
    localparam logic [1:0] K_DONE = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_NODIGIT = 3'd1;
    localparam logic [2:0] E_BADCHAR = 3'd2;
    localparam logic [2:0] E_TOOBIG  = 3'd3;
    localparam logic [2:0] E_NOCOMMA = 3'd4;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Classified input byte, as queued between front and back.
    typedef struct packed {
        logic       is_digit;
        logic       is_colon;
        logic       is_comma;
        logic [3:0] digit;
        logic [7:0] data;
    } class_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic   valid;
        class_t entry;
    } q_head_t;

endpackage

// File: rtl/core/nsd_if.sv
// Valid/ready channel interfaces: raw byte input and parse result output.
// No dependencies.
interface nsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface nsd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       last_payload;
    logic [2:0] error_code;

    modport source (output valid, output kind, output payload_byte,
                    output last_payload, output error_code, input ready);
    modport sink   (input valid, input kind, input payload_byte,
                    input last_payload, input error_code, output ready);
endinterface

// File: rtl/core/nsd_front.sv
// Front end: accepts raw bytes and classifies them for the parser.
// Depends on nsd_pkg and nsd_byte_if.
module nsd_front (
    nsd_byte_if.sink       bytes,
    input  logic           q_full,
    output logic           push,
    output nsd_pkg::class_t push_entry
);
    import nsd_pkg::*;

    logic [7:0] diff;

    assign bytes.ready = !q_full;
    assign push        = bytes.valid && !q_full;
    assign diff        = bytes.in_byte - CH_ZERO;

    always_comb
    begin
        push_entry.data     = bytes.in_byte;
        push_entry.is_digit = (bytes.in_byte >= CH_ZERO) && (bytes.in_byte <= CH_NINE);
        push_entry.is_colon = (bytes.in_byte == CH_COLON);
        push_entry.is_comma = (bytes.in_byte == CH_COMMA);
        push_entry.digit    = diff[3:0];
    end

endmodule

// File: rtl/core/nsd_fifo.sv
// Short queue of classified bytes between front and back end.
// Depends on nsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nsd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  nsd_pkg::class_t push_entry,
    input  logic            pop,
    output logic            full,
    output nsd_pkg::q_head_t head
);
    import nsd_pkg::*;

    class_t             mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_pop;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `NSD_ASSERT_ALWAYS(a_count_bound, count_reg <= Q_CNT_W'(Q_DEPTH), "queue count over depth")

endmodule

// File: rtl/core/nsd_back.sv
// Back end: netstring parser state and registered result stage.
// Depends on nsd_pkg, nsd_result_if and assert_macros.svh.
`include "assert_macros.svh"

module nsd_back #(
    parameter int LEN_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      max_length,
    input  nsd_pkg::q_head_t head,
    output logic             pop,
    nsd_result_if.source     results
);
    import nsd_pkg::*;

    localparam int CW = (LEN_BITS + 4 > 32) ? LEN_BITS + 4 : 32;

    logic [1:0]          phase_reg, phase_next;
    logic                seen_reg, seen_next;
    logic [LEN_BITS-1:0] count_reg, count_next;

    logic                valid_reg;
    logic [1:0]          kind_reg, kind_next;
    logic [7:0]          data_reg, data_next;
    logic                last_reg, last_next;
    logic [2:0]          err_reg, err_next;

    logic [CW-1:0]       new_len;
    logic [CW-1:0]       limit_ext;
    logic                too_big;
    logic [LEN_BITS-1:0] count_dec;
    class_t              e;

    assign e         = head.entry;
    assign pop       = head.valid && (!valid_reg || results.ready);
    assign limit_ext = CW'(max_length);
    assign new_len   = (CW'(count_reg) << 3) + (CW'(count_reg) << 1) + CW'(e.digit);
    assign too_big   = (new_len > limit_ext) || (new_len[CW-1:LEN_BITS] != '0);
    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        seen_next  = seen_reg;
        count_next = count_reg;
        kind_next  = K_HDR;
        data_next  = '0;
        last_next  = 1'b0;
        err_next   = E_NONE;
        case (phase_reg)
            PH_DATA:
            begin
                count_next = count_dec;
                kind_next  = K_DATA;
                data_next  = e.data;
                last_next  = (count_dec == '0);
                if (count_dec == '0)
                begin
                    phase_next = PH_COMMA;
                end
            end
            PH_COMMA:
            begin
                phase_next = PH_LEN;
                seen_next  = 1'b0;
                count_next = '0;
                if (e.is_comma)
                begin
                    kind_next = K_DONE;
                end
                else
                begin
                    kind_next = K_ERR;
                    err_next  = E_NOCOMMA;
                end
            end
            default:
            begin
                // length digits; the unused code behaves the same
                phase_next = PH_LEN;
                if (e.is_digit && !too_big)
                begin
                    count_next = new_len[LEN_BITS-1:0];
                    seen_next  = 1'b1;
                end
                else if (e.is_digit || !seen_reg || !e.is_colon)
                begin
                    seen_next  = 1'b0;
                    count_next = '0;
                    kind_next  = K_ERR;
                    if (e.is_digit)
                    begin
                        err_next = E_TOOBIG;
                    end
                    else if (!seen_reg)
                    begin
                        err_next = E_NODIGIT;
                    end
                    else
                    begin
                        err_next = E_BADCHAR;
                    end
                end
                else
                begin
                    phase_next = (count_reg == '0) ? PH_COMMA : PH_DATA;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
            seen_reg  <= 1'b0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                seen_reg  <= seen_next;
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            last_reg <= last_next;
            err_reg  <= err_next;
        end
    end

    assign results.valid        = valid_reg;
    assign results.kind         = kind_reg;
    assign results.payload_byte = data_reg;
    assign results.last_payload = last_reg;
    assign results.error_code   = err_reg;

    `NSD_ASSERT(a_data_count, (phase_reg == PH_DATA) |-> (count_reg != '0), "data phase with zero count")
    `NSD_ASSERT(a_last_kind, (valid_reg && last_reg) |-> (kind_reg == K_DATA), "last mark off data")
    `NSD_ASSERT(a_err_kind, valid_reg |-> ((err_reg != E_NONE) == (kind_reg == K_ERR)), "error code mismatch")

endmodule

// File: rtl/core/netstring_deframer_core.sv
// Netstring deframer: one byte in, one parse result out per byte.
// Each byte is written to the queue, then to the result register once that is free.
// Throughput: one byte per cycle while the result sink keeps ready high.
// Reset (rst_n low, asynchronous): parser waits for length digits, queue and result
// register empty, max_length back to 65535. No clearing pass; ready after reset.
module netstring_deframer_core #(
    parameter int LEN_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [31:0]   cfg_wr_data,
    nsd_byte_if.sink      bytes,
    nsd_result_if.source  results
);
    import nsd_pkg::*;

    logic       [31:0] max_length_reg;
    logic              q_full;
    logic              push;
    class_t            push_entry;
    logic              pop;
    q_head_t           head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_length_reg <= cfg_wr_data;
        end
    end

    nsd_front u_front (
        .bytes      (bytes),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    nsd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head       (head)
    );

    nsd_back #(
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_length (max_length_reg),
        .head       (head),
        .pop        (pop),
        .results    (results)
    );

endmodule

// File: tb/tb_netstring_deframer_core.sv
`timescale 1ns / 1ps
// Testbench of netstring_deframer_core: byte stream in, one parse result out per byte.
// Needs nsd_pkg and the nsd_byte_if / nsd_result_if interfaces from the RTL.
module tb_netstring_deframer_core;
    import nsd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic       last_payload;
        logic [2:0] error_code;
    } parse_result_t;

    // Tracks the parser state and the results still owed by the block.
    class netstring_scoreboard;
        logic [31:0]   max_length;
        logic [1:0]    phase;
        logic          digit_seen;
        logic [31:0]   count;
        parse_result_t parse_results[$];
        int            mismatches;

        function new();
            max_length = MAX_LENGTH_RESET;
            mismatches = 0;
            restart_parse();
        endfunction

        function void restart_parse();
            phase = PH_LEN;
            digit_seen = 1'b0;
            count = '0;
        endfunction

        function int pending();
            return parse_results.size();
        endfunction

        function parse_result_t parse_byte(logic [7:0] b);
            parse_result_t r;
            longint unsigned grown;
            r = '0;
            case (phase)
                PH_DATA:
                begin
                    count = count - 1;
                    r.kind = K_DATA;
                    r.payload_byte = b;
                    r.last_payload = (count == 0);
                    if (count == 0)
                        phase = PH_COMMA;
                end
                PH_COMMA:
                begin
                    restart_parse();
                    if (b == CH_COMMA)
                    begin
                        r.kind = K_DONE;
                    end
                    else
                    begin
                        r.kind = K_ERR;
                        r.error_code = E_NOCOMMA;
                    end
                end
                default:
                begin
                    r.kind = K_HDR;
                    if (b >= CH_ZERO && b <= CH_NINE)
                    begin
                        // widen so the overflow test cannot wrap
                        grown = longint'(count) * 10 + longint'(b - CH_ZERO);
                        if (grown > longint'(max_length))
                        begin
                            restart_parse();
                            r.kind = K_ERR;
                            r.error_code = E_TOOBIG;
                        end
                        else
                        begin
                            count = grown[31:0];
                            digit_seen = 1'b1;
                            phase = PH_LEN;
                        end
                    end
                    else if (!digit_seen)
                    begin
                        restart_parse();
                        r.kind = K_ERR;
                        r.error_code = E_NODIGIT;
                    end
                    else if (b != CH_COLON)
                    begin
                        restart_parse();
                        r.kind = K_ERR;
                        r.error_code = E_BADCHAR;
                    end
                    else
                    begin
                        phase = (count == 0) ? PH_COMMA : PH_DATA;
                    end
                end
            endcase
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            parse_results.push_back(parse_byte(b));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_result(parse_result_t got);
            parse_result_t want;
            if (parse_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind=%0d", got.kind));
            end
            else
            begin
                want = parse_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
                if (got.payload_byte !== want.payload_byte)
                    report_mismatch($sformatf("payload_byte %h, want %h",
                                              got.payload_byte, want.payload_byte));
                if (got.last_payload !== want.last_payload)
                    report_mismatch($sformatf("last_payload %b, want %b",
                                              got.last_payload, want.last_payload));
                if (got.error_code !== want.error_code)
                    report_mismatch($sformatf("error_code %0d, want %0d",
                                              got.error_code, want.error_code));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    int          idle_pct;
    int          stall_pct;
    int          cycles;
    int          bytes_sent;

    netstring_scoreboard sb;

    nsd_byte_if   bytes_ch();
    nsd_result_if results_ch();

    netstring_deframer_core #(
        .LEN_BITS (32)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .bytes       (bytes_ch),
        .results     (results_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        results_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid && results_ch.ready)
            sb.check_result({results_ch.kind, results_ch.payload_byte,
                             results_ch.last_payload, results_ch.error_code});
    end

    task send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            bytes_ch.valid <= 1'b0;
            @(posedge clk);
        end
        bytes_ch.valid   <= 1'b1;
        bytes_ch.in_byte <= b;
        @(posedge clk);
        while (!bytes_ch.ready)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Drop valid and hold until every owed result has been taken.
    task hold_until_drained();
        bytes_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_max_length(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.max_length = value;
    endtask

    function logic [7:0] pick_non_digit(bit colon_ok);
        logic [7:0] b;
        b = $urandom_range(0, 245);
        // skip over the ten digit codes
        if (b >= CH_ZERO)
            b = b + 8'd10;
        if (!colon_ok && b == CH_COLON)
            b = CH_COMMA;
        return b;
    endfunction

    task automatic send_random_frame();
        int              r;
        int              len;
        int              cap;
        int              pause_at;
        longint unsigned big;
        string           digits;
        logic [7:0]      frame[$];
        r = $urandom_range(99);
        if (r < 78)
        begin
            cap = (sb.max_length < 16) ? int'(sb.max_length) : 16;
            len = $urandom_range(0, cap);
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 3)) frame.push_back(CH_ZERO);
            digits = $sformatf("%0d", len);
            for (int i = 0; i < digits.len(); i++)
                frame.push_back(digits[i]);
            frame.push_back(CH_COLON);
            repeat (len) frame.push_back($urandom_range(0, 255));
            if (r < 70)
                frame.push_back(CH_COMMA);
            else
                frame.push_back(CH_COMMA ^ 8'($urandom_range(1, 255)));
        end
        else if (r < 84)
        begin
            big = longint'(sb.max_length) + 1 + $urandom_range(0, 1000);
            digits = $sformatf("%0d", big);
            for (int i = 0; i < digits.len(); i++)
                frame.push_back(digits[i]);
            // close with junk so leftover digits never open a long payload
            frame.push_back(pick_non_digit(1'b0));
        end
        else if (r < 90)
        begin
            digits = $sformatf("%0d", $urandom_range(0, 999));
            for (int i = 0; i < digits.len(); i++)
                frame.push_back(digits[i]);
            frame.push_back(pick_non_digit(1'b0));
        end
        else if (r < 95)
        begin
            frame.push_back(pick_non_digit(1'b1));
        end
        else
        begin
            repeat ($urandom_range(1, 3)) frame.push_back($urandom_range(0, 255));
        end

        pause_at = ($urandom_range(49) == 0) ? $urandom_range(0, frame.size() - 1) : -1;
        for (int i = 0; i < frame.size(); i++)
        begin
            send_byte(frame[i]);
            if (i == pause_at)
                hold_until_drained();
        end
    endtask

    initial
    begin
        logic [31:0] limits[8];
        int          seg_start;
        sb = new();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        bytes_ch.valid = 1'b0;
        bytes_ch.in_byte = '0;
        results_ch.ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        cycles = 0;
        bytes_sent = 0;
        limits = '{32'hFFFF_FFFF, 32'd0, MAX_LENGTH_RESET, 32'd9, 32'd10, 32'd100,
                   32'd0, 32'd0};
        limits[6] = $urandom_range(1, 40);
        limits[7] = $urandom;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty frame, leading zero with extreme payload bytes
        send_text("0:,");
        send_text("02:");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_COMMA);
        // colon before digits, bad length character, missing comma
        send_text(":1a");
        send_text("1:Zx");
        // tighten the limit between two digits of one length
        send_text("1");
        hold_until_drained();
        write_max_length(32'd5);
        send_text("2");
        hold_until_drained();
        write_max_length(32'hFFFF_FFFF);
        send_text("4294967296");

        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 85; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            hold_until_drained();
            write_max_length(limits[seg]);
            seg_start = bytes_sent;
            while (bytes_sent - seg_start < 240)
                send_random_frame();
        end

        hold_until_drained();
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/nsd_pkg.sv
rtl/core/nsd_if.sv
rtl/core/nsd_front.sv
rtl/core/nsd_fifo.sv
rtl/core/nsd_back.sv
rtl/core/netstring_deframer_core.sv
tb/tb_netstring_deframer_core.sv
